/* src/dpb_pkg.sv */
// Package for the disk parameter block derivation.
// Holds field widths, payload and sequencer types shared by the interfaces,
// the top level and the checker. No dependencies.
package dpb_pkg;

   localparam int RECORD_BYTES = 128;
   localparam int REC_SHIFT    = $clog2(RECORD_BYTES);

   localparam int SPT_W    = 10;
   localparam int SSZ_W    = 15;
   localparam int TRK_W    = 16;
   localparam int IMG_W    = 32;
   localparam int RPS_W    = SSZ_W - REC_SHIFT;
   localparam int RPT_W    = SPT_W + RPS_W;
   localparam int TB_W     = RPT_W + REC_SHIFT;
   localparam int TRACKS_W = IMG_W - REC_SHIFT;
   localparam int REC_W    = TRACKS_W + RPT_W;
   localparam int UNIT_W   = REC_W + 1;
   localparam int BCNT_W   = 17;
   localparam int BCNT_MAX = 65536;
   localparam int CNT_W    = 5;
   localparam int DBLK_W   = 5;
   localparam int DENT_W   = 10;

   localparam int DIV_STEPS = IMG_W;
   localparam int MUL_STEPS = RPT_W;

   localparam int DIR_SLOTS       = 64;
   localparam int DIR_ENTRY_BYTES = 32;
   localparam int DIR_RECORDS     = DIR_SLOTS * DIR_ENTRY_BYTES / RECORD_BYTES;
   localparam int ENTRY_SHIFT     = REC_SHIFT - $clog2(DIR_ENTRY_BYTES);
   localparam int SYS_TRACKS      = 2;
   localparam int RPT_SAT         = 65535;

   typedef struct packed {
      logic [SPT_W-1:0] sec_per_trk;
      logic [SSZ_W-1:0] sec_bytes;
      logic [TRK_W-1:0] trk_total;
      logic [IMG_W-1:0] img_bytes;
   } req_payload_type;

   typedef struct packed {
      logic        valid_res;
      logic [15:0] records_per_track_out;
      logic [2:0]  block_shift;
      logic [6:0]  block_mask;
      logic [2:0]  extent_mask;
      logic [15:0] last_block;
      logic [8:0]  last_dir_entry;
      logic [7:0]  dir_alloc_high;
      logic [7:0]  dir_alloc_low;
      logic [7:0]  check_size;
      logic [1:0]  sys_tracks_out;
      logic [13:0] alloc_vector_bytes;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_MUL,
      ST_SIZE,
      ST_DONE
   } state_type;

endpackage

/* src/dpb_req_if.sv */
// Geometry request channel: valid/ready handshake with the geometry payload.
// Depends on dpb_pkg.
interface dpb_req_if
   import dpb_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
   modport monitor (input valid, input ready, input data);
endinterface

/* src/dpb_rsp_if.sv */
// Parameter block result channel: valid/ready handshake with the result payload.
// Depends on dpb_pkg.
interface dpb_rsp_if
   import dpb_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
   modport monitor (input valid, input ready, input data);
endinterface

/* src/disk_parameter_block_derive.sv */
// Disk parameter block derivation: geometry in, CP/M-style parameter block out.
// Depends on dpb_pkg, dpb_req_if and dpb_rsp_if.
//
// Usage:
//   req_channel carries one geometry per transfer; rsp_channel returns one
//   parameter block per geometry, in order. req_channel.ready is high only
//   while the sequencer is idle, so one geometry is worked on at a time.
//   A single 44-bit add/subtract unit does all the heavy arithmetic: a
//   radix-2 restoring divide (32 steps) of image size by track bytes when
//   the track count is zero, then a shift-add multiply (18 steps) of data
//   tracks by records per track.
//   A geometry rejected outright goes straight to the final step.
//   The result lands in the output register at the edge where the sequencer
//   goes idle again; a new geometry may be taken while that result still
//   waits. When the receiver stalls, the result is held and the next result
//   waits in its final step until the output register empties.
//   Synchronous reset returns the sequencer to idle and drops rsp valid.
module disk_parameter_block_derive
   import dpb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   dpb_req_if.sink    req_channel,
   dpb_rsp_if.source  rsp_channel
);

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;
   logic [TB_W-1:0]       rem_ff, rem_in;
   logic [IMG_W-1:0]      quo_ff, quo_in;
   logic [RPT_W-1:0]      rpt_ff, rpt_in;
   logic [TRACKS_W-1:0]   tracks_ff, tracks_in;
   logic                  reserved_ff, reserved_in;
   logic [REC_W-1:0]      mcand_ff, mcand_in;
   logic [RPT_W-1:0]      mplier_ff, mplier_in;
   logic [REC_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [2:0]            k_ff, k_in;
   logic [BCNT_W-1:0]     bcount_ff, bcount_in;
   logic                  bad_ff, bad_in;

   // shared add/subtract unit
   logic [UNIT_W-1:0]     unit_a, unit_b, unit_res;
   logic                  unit_sub;
   logic [TB_W:0]         div_trial;
   logic [TB_W-1:0]       trk_bytes;

   logic [2:0]            size_k;
   logic [REC_W-1:0]      size_shifted;
   logic [BCNT_W-1:0]     size_bcount;

   logic [DBLK_W-1:0]     dblk0, dblk_shrink, dblk;
   logic                  shrink;
   logic [DENT_W-1:0]     dent;
   logic [15:0]           dent_shift;
   rsp_payload_type       result;

   assign trk_bytes = {rpt_ff, REC_SHIFT'(0)};
   assign div_trial = {rem_ff, quo_ff[IMG_W-1]};

   always_comb begin
      unit_sub = 1'b0;
      unit_a   = UNIT_W'(acc_ff);
      unit_b   = mplier_ff[0] ? UNIT_W'(mcand_ff) : '0;
      if (state_ff == ST_DIV) begin
         unit_sub = 1'b1;
         unit_a   = UNIT_W'(div_trial);
         unit_b   = UNIT_W'(trk_bytes);
      end
   end

   assign unit_res = unit_sub ? (unit_a - unit_b) : (unit_a + unit_b);

   // block size: smallest power of two from 8 keeping the count within
   // 16 bits, capped at 128; shrink to the data size on tiny disks
   always_comb begin
      priority if (|acc_ff[REC_W-1:22]) size_k = 3'd7;
      else if (|acc_ff[REC_W-1:21])     size_k = 3'd6;
      else if (|acc_ff[REC_W-1:20])     size_k = 3'd5;
      else if (|acc_ff[REC_W-1:19])     size_k = 3'd4;
      else if (|acc_ff[REC_W-1:3])      size_k = 3'd3;
      else if (acc_ff[2])               size_k = 3'd2;
      else if (acc_ff[1])               size_k = 3'd1;
      else                              size_k = 3'd0;
      size_shifted = acc_ff >> size_k;
      size_bcount  = (size_shifted > REC_W'(BCNT_MAX)) ? BCNT_W'(BCNT_MAX)
                                                       : size_shifted[BCNT_W-1:0];
   end

   // directory sizing and result assembly
   always_comb begin
      dblk0       = (k_ff <= 3'd4) ? (DBLK_W'(DIR_RECORDS) >> k_ff) : DBLK_W'(1);
      shrink      = BCNT_W'(dblk0) >= bcount_ff;
      dblk_shrink = (bcount_ff > BCNT_W'(1)) ? (bcount_ff[DBLK_W-1:0] - DBLK_W'(1))
                                             : DBLK_W'(1);
      dblk        = shrink ? dblk_shrink : dblk0;
      dent_shift  = 16'(dblk_shrink) << (4'(k_ff) + 4'(ENTRY_SHIFT));
      dent        = shrink ? dent_shift[DENT_W-1:0] : DENT_W'(DIR_SLOTS);

      result = '0;
      if (!bad_ff) begin
         result.valid_res             = 1'b1;
         result.records_per_track_out = (rpt_ff > RPT_W'(RPT_SAT)) ? 16'(RPT_SAT)
                                                                   : rpt_ff[15:0];
         result.block_shift           = k_ff;
         result.block_mask            = 7'((8'd1 << k_ff) - 8'd1);
         unique case (k_ff)
            3'd5:    result.extent_mask = 3'd1;
            3'd6:    result.extent_mask = 3'd3;
            3'd7:    result.extent_mask = 3'd7;
            default: result.extent_mask = 3'd0;
         endcase
         result.last_block            = 16'(bcount_ff - BCNT_W'(1));
         result.last_dir_entry        = 9'(dent - DENT_W'(1));
         result.dir_alloc_high        = ~(8'hFF >> ((dblk > DBLK_W'(8)) ? 4'd8 : 4'(dblk)));
         result.dir_alloc_low         = (dblk > DBLK_W'(8))
                                        ? ~(8'hFF >> 4'(dblk - DBLK_W'(8))) : 8'h00;
         result.check_size            = 8'(dent >> 2);
         result.sys_tracks_out        = reserved_ff ? 2'(SYS_TRACKS) : 2'd0;
         result.alloc_vector_bytes    = 14'((18'(bcount_ff) + 18'd7) >> 3);
      end
   end

   assign req_channel.ready = (state_ff == ST_IDLE);
   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      rsp_data_in  = rsp_data_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rpt_in       = rpt_ff;
      tracks_in    = tracks_ff;
      reserved_in  = reserved_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      bcount_in    = bcount_ff;
      bad_in       = bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_channel.valid) begin
               rpt_in    = RPT_W'(req_channel.data.sec_per_trk)
                           * RPT_W'(req_channel.data.sec_bytes[SSZ_W-1:REC_SHIFT]);
               rem_in    = '0;
               quo_in    = req_channel.data.img_bytes;
               tracks_in = TRACKS_W'(req_channel.data.trk_total);
               cnt_in    = '0;
               bad_in    = 1'b0;
               if (req_channel.data.sec_per_trk == '0 ||
                   req_channel.data.sec_bytes == '0 ||
                   req_channel.data.sec_bytes[REC_SHIFT-1:0] != '0) begin
                  bad_in   = 1'b1;
                  state_in = ST_DONE;
               end else if (req_channel.data.trk_total == '0) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_DIV: begin
            // restoring step: keep the difference when it did not borrow
            if (!unit_res[UNIT_W-1]) begin
               rem_in = unit_res[TB_W-1:0];
               quo_in = {quo_ff[IMG_W-2:0], 1'b1};
            end else begin
               rem_in = div_trial[TB_W-1:0];
               quo_in = {quo_ff[IMG_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               tracks_in = quo_in[TRACKS_W-1:0];
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            if (tracks_ff == '0) begin
               bad_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               reserved_in = tracks_ff > TRACKS_W'(SYS_TRACKS);
               mcand_in    = REC_W'(tracks_ff - (reserved_in ? TRACKS_W'(SYS_TRACKS)
                                                             : TRACKS_W'(0)));
               mplier_in   = rpt_ff;
               acc_in      = '0;
               cnt_in      = '0;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in    = unit_res[REC_W-1:0];
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            k_in      = size_k;
            bcount_in = size_bcount;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // hold here until the output register is free
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rpt_ff      <= rpt_in;
      tracks_ff   <= tracks_in;
      reserved_ff <= reserved_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      bcount_ff   <= bcount_in;
      bad_ff      <= bad_in;
   end

endmodule

/* src/dpb_checker.sv */
// Port-level checks for disk_parameter_block_derive, attached by bind.
// Depends on dpb_pkg and the handshake and payload signals of the top level's channels.
module dpb_checker
   import dpb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // busy after taking a geometry
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after a transfer");

   // a rejected geometry gives an all-zero block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data == '0)
      else $error("invalid result carries nonzero fields");

   // block mask agrees with block shift
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_res |->
         rsp_data.block_mask == 7'((8'd1 << rsp_data.block_shift) - 8'd1))
      else $error("block mask does not match block shift");

endmodule

bind disk_parameter_block_derive dpb_checker u_dpb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_channel.valid),
   .req_ready (req_channel.ready),
   .rsp_valid (rsp_channel.valid),
   .rsp_ready (rsp_channel.ready),
   .rsp_data  (rsp_channel.data)
);

/* bench/disk_parameter_block_derive_test.sv */
// Testbench for disk_parameter_block_derive: drives geometries, predicts each
// parameter block and checks every result transfer field by field.
// Depends on dpb_pkg, dpb_req_if, dpb_rsp_if and the block itself.
`timescale 1ns / 100ps

module disk_parameter_block_derive_test;
   import dpb_pkg::*;

   logic clock = 1'b0;
   logic reset;

   dpb_req_if req_if ();
   dpb_rsp_if rsp_if ();

   disk_parameter_block_derive i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_if),
      .rsp_channel (rsp_if)
   );

   always #4 clock = ~clock;

   rsp_payload_type expected_blocks[$];
   int unsigned     mismatch_count = 0;
   int unsigned     req_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   int              rsp_hold_request = 0;
   int              rsp_hold_left = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Predict the parameter block for one geometry.
   function automatic rsp_payload_type derive_parameter_block(input req_payload_type g);
      rsp_payload_type   blk;
      longint unsigned   spt, ssz, recs_per_track, trk_len, tracks, reserved;
      longint unsigned   data_recs, blk_recs, pow, blk_count, blk_bytes, entries;
      longint unsigned   dir_blks;
      logic [15:0]       alloc_map;
      int                shift;
      blk = '0;
      spt = 64'(g.sec_per_trk);
      ssz = 64'(g.sec_bytes);
      if (spt == 0 || ssz == 0 || ssz[6:0] != 0)
         return blk;
      recs_per_track = spt * (ssz >> REC_SHIFT);
      trk_len = spt * ssz;
      tracks = 64'(g.trk_total);
      if (tracks == 0)
         tracks = longint'(g.img_bytes) / trk_len;
      if (tracks == 0)
         return blk;
      reserved = (tracks > 2) ? 2 : 0;
      data_recs = (tracks - reserved) * recs_per_track;
      if (data_recs == 0)
         return blk;

      blk_recs = 8;
      while (blk_recs < 2048 && data_recs / blk_recs > 64'hFFFF)
         blk_recs = blk_recs << 1;
      if (blk_recs > 128)
         blk_recs = 128;
      // tiny disk: fall back to the largest power of two that fits
      if (blk_recs > data_recs) begin
         pow = 1;
         while ((pow << 1) <= data_recs)
            pow = pow << 1;
         blk_recs = pow;
      end
      blk_count = data_recs / blk_recs;
      if (blk_count == 0)
         blk_count = 1;
      if (blk_count > BCNT_MAX)
         blk_count = BCNT_MAX;
      shift = $clog2(blk_recs);

      blk_bytes = blk_recs * RECORD_BYTES;
      entries = DIR_SLOTS;
      dir_blks = (DIR_SLOTS * DIR_ENTRY_BYTES + blk_bytes - 1) / blk_bytes;
      if (dir_blks == 0)
         dir_blks = 1;
      // shrink the directory so that one data block stays free
      if (dir_blks >= blk_count) begin
         dir_blks = (blk_count > 1) ? blk_count - 1 : 1;
         entries = (dir_blks * blk_bytes) / DIR_ENTRY_BYTES;
      end
      if (entries == 0)
         entries = DIR_ENTRY_BYTES;
      if (entries > 64'hFFFF)
         entries = 64'hFFFF;
      alloc_map = '0;
      for (int i = 0; i < 16; i++)
         if (i < dir_blks)
            alloc_map[15 - i] = 1'b1;

      blk.valid_res             = 1'b1;
      blk.records_per_track_out = (recs_per_track > 64'hFFFF) ? 16'hFFFF : recs_per_track[15:0];
      blk.block_shift           = shift[2:0];
      blk.block_mask            = 7'(blk_recs - 1);
      blk.extent_mask           = (blk_recs <= 16) ? 3'd0 : (blk_recs <= 32) ? 3'd1 :
                                  (blk_recs <= 64) ? 3'd3 : 3'd7;
      blk.last_block            = 16'(blk_count - 1);
      blk.last_dir_entry        = 9'(entries - 1);
      blk.dir_alloc_high        = alloc_map[15:8];
      blk.dir_alloc_low         = alloc_map[7:0];
      blk.check_size            = 8'(entries / 4);
      blk.sys_tracks_out        = reserved[1:0];
      blk.alloc_vector_bytes    = 14'((blk_count + 7) / 8);
      return blk;
   endfunction

   function automatic req_payload_type make_geometry(input int unsigned spt,
      input int unsigned ssz, input int unsigned tracks, input logic [31:0] image);
      req_payload_type g;
      g.sec_per_trk = spt[SPT_W-1:0];
      g.sec_bytes   = ssz[SSZ_W-1:0];
      g.trk_total   = tracks[TRK_W-1:0];
      g.img_bytes   = image;
      return g;
   endfunction

   function automatic req_payload_type random_geometry();
      req_payload_type g;
      int unsigned     kind, spt, ssz, tracks;
      longint unsigned trk_len, image;
      kind = $urandom_range(99);
      spt = ($urandom_range(3) == 0) ? $urandom_range(1023, 1) : $urandom_range(64, 1);
      if ($urandom_range(1) == 0)
         ssz = RECORD_BYTES << $urandom_range(7);
      else
         ssz = RECORD_BYTES * $urandom_range(255, 1);
      case ($urandom_range(3))
         0: tracks = $urandom_range(4, 1);
         1: tracks = $urandom_range(200, 40);
         default: tracks = $urandom_range(65535, 1);
      endcase
      image = 64'($urandom());
      if (kind >= 85) begin
         // noise: any field pattern at all
         g.sec_per_trk = SPT_W'($urandom());
         g.sec_bytes   = SSZ_W'($urandom());
         g.trk_total   = TRK_W'($urandom());
         g.img_bytes   = $urandom();
         return g;
      end
      if (kind >= 60) begin
         // derive the track count from an image near a whole number of tracks
         trk_len = longint'(spt) * ssz;
         image = trk_len * (($urandom_range(1) == 0) ? $urandom_range(5) :
                            $urandom_range(3000)) + $urandom_range(32'(trk_len - 1));
         if (image > 64'hFFFF_FFFF)
            image = 64'($urandom());
         tracks = 0;
      end
      return make_geometry(spt, ssz, tracks, image[31:0]);
   endfunction

   // Offer one geometry and wait for its transfer; valid stays high for a
   // following item unless an idle cycle comes first.
   task automatic send_geometry(input req_payload_type g);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= g;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      expected_blocks.push_back(derive_parameter_block(g));
   endtask

   always @(posedge clock) begin
      if (rsp_hold_request != 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("parameter block with no geometry outstanding");
         end else begin
            want = expected_blocks.pop_front();
            check_field("valid_res", 32'(rsp_if.data.valid_res), 32'(want.valid_res));
            check_field("records_per_track_out", 32'(rsp_if.data.records_per_track_out),
                        32'(want.records_per_track_out));
            check_field("block_shift", 32'(rsp_if.data.block_shift),
                        32'(want.block_shift));
            check_field("block_mask", 32'(rsp_if.data.block_mask), 32'(want.block_mask));
            check_field("extent_mask", 32'(rsp_if.data.extent_mask),
                        32'(want.extent_mask));
            check_field("last_block", 32'(rsp_if.data.last_block), 32'(want.last_block));
            check_field("last_dir_entry", 32'(rsp_if.data.last_dir_entry),
                        32'(want.last_dir_entry));
            check_field("dir_alloc_high", 32'(rsp_if.data.dir_alloc_high),
                        32'(want.dir_alloc_high));
            check_field("dir_alloc_low", 32'(rsp_if.data.dir_alloc_low),
                        32'(want.dir_alloc_low));
            check_field("check_size", 32'(rsp_if.data.check_size), 32'(want.check_size));
            check_field("sys_tracks_out", 32'(rsp_if.data.sys_tracks_out),
                        32'(want.sys_tracks_out));
            check_field("alloc_vector_bytes", 32'(rsp_if.data.alloc_vector_bytes),
                        32'(want.alloc_vector_bytes));
         end
      end
   end

   task automatic test_invalid_geometry();
      send_geometry(make_geometry(0, 512, 40, 32'h0010_0000));
      send_geometry(make_geometry(9, 0, 40, 32'h0010_0000));
      send_geometry(make_geometry(9, 200, 40, 32'h0010_0000));
      send_geometry(make_geometry(9, 32767, 40, 32'h0010_0000));
      // derived track count comes out zero
      send_geometry(make_geometry(9, 512, 0, 4607));
      send_geometry(make_geometry(9, 512, 0, 0));
   endtask

   task automatic test_block_sizes();
      send_geometry(make_geometry(26, 128, 77, 0));
      send_geometry(make_geometry(512, 1024, 1000, 0));
      send_geometry(make_geometry(64, 1024, 1500, 0));
      send_geometry(make_geometry(64, 1024, 3000, 0));
      send_geometry(make_geometry(64, 1024, 6000, 0));
      send_geometry(make_geometry(1, 16384, 65535, 32'h0));
      send_geometry(make_geometry(1023, 128, 1, 32'h5555_AAAA));
   endtask

   task automatic test_field_extremes();
      // oversized sector, saturated records per track, capped block count
      send_geometry(make_geometry(1023, 32640, 65535, 32'hFFFF_FFFF));
      send_geometry(make_geometry(1023, 16384, 65535, 32'hFFFF_FFFF));
      send_geometry(make_geometry(1, 32640, 3, 32'h0));
   endtask

   task automatic test_tiny_disk();
      send_geometry(make_geometry(1, 128, 1, 0));
      send_geometry(make_geometry(3, 128, 2, 0));
      send_geometry(make_geometry(1, 128, 3, 0));
      send_geometry(make_geometry(5, 256, 2, 0));
   endtask

   task automatic test_derived_tracks();
      send_geometry(make_geometry(9, 512, 0, 9 * 512 * 3));
      send_geometry(make_geometry(1023, 16384, 0, 32'hFFFF_FFFF));
      send_geometry(make_geometry(18, 512, 0, 1474559));
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct, input int count);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count)
         send_geometry(random_geometry());
   endtask

   // Hold the result side off for a long stretch while geometries keep coming.
   task automatic test_backpressure();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_request = 400;
      repeat (20)
         send_geometry(random_geometry());
   endtask

   initial begin
      int wait_cycles;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_invalid_geometry();
      test_block_sizes();
      test_field_extremes();
      test_tiny_disk();
      test_derived_tracks();
      test_random_traffic(0, 0, 125);
      test_random_traffic(50, 0, 125);
      test_random_traffic(0, 50, 125);
      test_random_traffic(30, 30, 125);
      test_backpressure();
      req_if.valid <= 1'b0;
      rsp_stall_pct = 0;

      wait_cycles = 0;
      while (expected_blocks.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_blocks.size() != 0)
         report_mismatch($sformatf("%0d parameter blocks never arrived",
                                   expected_blocks.size()));
      repeat (100)
         @(posedge clock);

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
